[hw/rtl/slcfp_pkg.sv]
// Shared types and constants for the sync/length/checksum frame parser.
// No dependencies; read by the interfaces, the parser core and the top level.
package slcfp_pkg;

   localparam int BYTE_W = 8;

   localparam logic [BYTE_W-1:0] SYNC_FIRST        = 8'h55;
   localparam logic [BYTE_W-1:0] SYNC_SECOND       = 8'hAA;
   localparam logic [BYTE_W-1:0] LIMIT_CAP         = 8'd252;
   localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RESET = 8'd64;

   typedef enum logic [1:0] {
      ROLE_LENGTH   = 2'd0,
      ROLE_COMMAND  = 2'd1,
      ROLE_PAYLOAD  = 2'd2,
      ROLE_CHECKSUM = 2'd3
   } role_type;

   typedef enum logic [1:0] {
      STATUS_BUSY   = 2'd0,
      STATUS_GOOD   = 2'd1,
      STATUS_BAD    = 2'd2,
      STATUS_REJECT = 2'd3
   } status_type;

   typedef struct packed {
      logic              in_frame;
      logic              sync_seen;
      logic [BYTE_W-1:0] byte_count;
      logic [BYTE_W-1:0] length_held;
      logic [BYTE_W-1:0] running_sum;
   } state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] frame_byte;
      role_type          byte_role;
      logic [BYTE_W-1:0] byte_position;
      logic [BYTE_W-1:0] frame_length;
      logic              frame_end;
      status_type        frame_status;
   } result_type;

endpackage

[hw/rtl/slcfp_req_if.sv]
// Input byte channel: valid/ready handshake carrying one received byte.
// Depends on slcfp_pkg.
interface slcfp_req_if;
   import slcfp_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

[hw/rtl/slcfp_rsp_if.sv]
// Result channel: valid/ready handshake carrying one tagged frame byte.
// Depends on slcfp_pkg.
interface slcfp_rsp_if;
   import slcfp_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] frame_byte;
   logic [1:0]        byte_role;
   logic [BYTE_W-1:0] byte_position;
   logic [BYTE_W-1:0] frame_length;
   logic              frame_end;
   logic [1:0]        frame_status;

   modport source (output valid, output frame_byte, output byte_role, output byte_position,
                   output frame_length, output frame_end, output frame_status, input ready);
   modport sink   (input valid, input frame_byte, input byte_role, input byte_position,
                   input frame_length, input frame_end, input frame_status, output ready);
endinterface

[hw/rtl/slcfp_core.sv]
// Parser step: sync hunt, frame field tagging, running checksum and length check.
// Purely combinational; depends on slcfp_pkg.
module slcfp_core (
   input  slcfp_pkg::state_type            state,
   input  logic [slcfp_pkg::BYTE_W-1:0]    in_byte,
   input  logic [slcfp_pkg::BYTE_W-1:0]    max_payload,
   output slcfp_pkg::state_type            next_state,
   output logic                            has_result,
   output slcfp_pkg::result_type           result
);
   import slcfp_pkg::*;

   logic [BYTE_W-1:0] limit;
   logic [BYTE_W:0]   last_pos;
   logic [BYTE_W-1:0] sum_next;
   logic              frame_done;

   assign limit    = (max_payload > LIMIT_CAP) ? LIMIT_CAP : max_payload;
   assign last_pos = {1'b0, state.length_held} + (BYTE_W+1)'(2);
   assign sum_next = state.running_sum + in_byte;

   always_comb begin
      next_state            = state;
      has_result            = 1'b0;
      frame_done            = 1'b0;
      result.frame_byte     = in_byte;
      result.byte_role      = ROLE_LENGTH;
      result.byte_position  = state.byte_count;
      result.frame_length   = state.length_held;
      result.frame_end      = 1'b0;
      result.frame_status   = STATUS_BUSY;

      if (!state.in_frame) begin
         if (in_byte == SYNC_FIRST) begin
            next_state.sync_seen = 1'b1;
         end else if (state.sync_seen && in_byte == SYNC_SECOND) begin
            next_state.in_frame    = 1'b1;
            next_state.sync_seen   = 1'b0;
            next_state.byte_count  = '0;
            next_state.length_held = '0;
            next_state.running_sum = '0;
         end
      end else if (state.byte_count == '0) begin
         has_result          = 1'b1;
         result.frame_length = in_byte;
         if (in_byte > limit) begin
            result.frame_status = STATUS_REJECT;
            frame_done          = 1'b1;
         end else begin
            next_state.length_held = in_byte;
            next_state.running_sum = in_byte;
            next_state.byte_count  = BYTE_W'(1);
         end
      end else begin
         has_result             = 1'b1;
         next_state.running_sum = sum_next;
         if (state.byte_count == BYTE_W'(1)) begin
            result.byte_role = ROLE_COMMAND;
         end else if ({1'b0, state.byte_count} < last_pos) begin
            result.byte_role = ROLE_PAYLOAD;
         end else begin
            result.byte_role = ROLE_CHECKSUM;
         end
         if (result.byte_role == ROLE_CHECKSUM) begin
            result.frame_status = (sum_next == '0) ? STATUS_GOOD : STATUS_BAD;
            frame_done          = 1'b1;
         end else begin
            next_state.byte_count = state.byte_count + BYTE_W'(1);
         end
      end

      if (frame_done) begin
         result.frame_end       = 1'b1;
         next_state.in_frame    = 1'b0;
         next_state.byte_count  = '0;
         next_state.length_held = '0;
         next_state.running_sum = '0;
      end
   end

endmodule

[hw/rtl/sync_length_checksum_frame_parser.sv]
// Sync/length/checksum frame parser. Takes one received byte per transfer and
// emits each frame byte tagged with role, position, length and status.
// Depends on slcfp_pkg, slcfp_req_if, slcfp_rsp_if and slcfp_core.
//
// Usage: one byte is accepted every cycle unless the input side stalls. Each
// byte is held in the input register, where the parser step updates the frame
// state, and then sits in the result register until taken. Sync bytes and bytes
// seen while hunting produce no result. Throughput is set by the single parser
// step between the two registers; the input side stalls only while the result
// register is full and not drained. max_payload is to be written through
// csr_we/csr_wdata only while the parser is idle; the block does not enforce
// this. Values above 252 act as 252. It resets to 64.
module sync_length_checksum_frame_parser (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [slcfp_pkg::BYTE_W-1:0] csr_wdata,
   slcfp_req_if.sink                    req,
   slcfp_rsp_if.source                  rsp
);
   import slcfp_pkg::*;

   logic [BYTE_W-1:0] max_payload_ff, max_payload_in;
   state_type         state_ff, state_in;
   logic              s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0] s1_byte_ff, s1_byte_in;
   logic              out_valid_ff, out_valid_in;
   result_type        out_ff, out_in;

   state_type         core_state;
   logic              core_has_result;
   result_type        core_result;
   logic              out_free;
   logic              s1_advance;
   logic              req_take;

   slcfp_core u_core (
      .state       (state_ff),
      .in_byte     (s1_byte_ff),
      .max_payload (max_payload_ff),
      .next_state  (core_state),
      .has_result  (core_has_result),
      .result      (core_result)
   );

   assign out_free   = !out_valid_ff || rsp.ready;
   assign s1_advance = s1_valid_ff && out_free;
   assign req.ready  = !s1_valid_ff || out_free;
   assign req_take   = req.valid && req.ready;

   always_comb begin
      max_payload_in = csr_we ? csr_wdata : max_payload_ff;
      state_in       = s1_advance ? core_state : state_ff;
      s1_valid_in    = req_take || (s1_valid_ff && !s1_advance);
      s1_byte_in     = req_take ? req.in_byte : s1_byte_ff;
      out_valid_in   = out_valid_ff && !rsp.ready;
      out_in         = out_ff;
      if (s1_advance && core_has_result) begin
         out_valid_in = 1'b1;
         out_in       = core_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MAX_PAYLOAD_RESET;
         state_ff       <= '0;
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         max_payload_ff <= max_payload_in;
         state_ff       <= state_in;
         s1_valid_ff    <= s1_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_byte_ff <= s1_byte_in;
      out_ff     <= out_in;
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.frame_byte    = out_ff.frame_byte;
   assign rsp.byte_role     = out_ff.byte_role;
   assign rsp.byte_position = out_ff.byte_position;
   assign rsp.frame_length  = out_ff.frame_length;
   assign rsp.frame_end     = out_ff.frame_end;
   assign rsp.frame_status  = out_ff.frame_status;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for sync_length_checksum_frame_parser: directed and random
// byte streams, a byte-level parser predictor and a scoreboard. Needs slcfp_pkg and
// the slcfp_req_if / slcfp_rsp_if interfaces.
module tb_top;
   import slcfp_pkg::*;

   localparam int STALL_LIMIT = 1000;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_we;
   logic [BYTE_W-1:0] csr_wdata;

   slcfp_req_if req ();
   slcfp_rsp_if rsp ();

   sync_length_checksum_frame_parser u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req       (req),
      .rsp       (rsp)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stimulus and scoreboard storage
   logic [BYTE_W-1:0] link_bytes[$];
   result_type        results_due[$];
   int                send_idle_pct = 0;
   int                recv_stall_pct = 0;
   int                gen_limit;
   int                frame_bytes_queued = 0;
   int                mismatches = 0;
   int                idle_cycles = 0;

   // predictor state
   logic              framing;
   logic              sync_armed;
   logic [BYTE_W-1:0] pos_next;
   logic [BYTE_W-1:0] len_held;
   logic [BYTE_W-1:0] sum_acc;
   logic [BYTE_W-1:0] payload_limit;

   function automatic void clear_frame();
      framing  = 1'b0;
      pos_next = '0;
      len_held = '0;
      sum_acc  = '0;
   endfunction

   function automatic bit parse_byte(input logic [BYTE_W-1:0] b, output result_type r);
      logic [BYTE_W-1:0] lim;
      logic [BYTE_W:0]   last;
      r = '0;
      if (!framing) begin
         if (b == SYNC_FIRST) begin
            sync_armed = 1'b1;
         end else if (sync_armed && b == SYNC_SECOND) begin
            clear_frame();
            framing    = 1'b1;
            sync_armed = 1'b0;
         end
         return 1'b0;
      end
      lim = (payload_limit > LIMIT_CAP) ? LIMIT_CAP : payload_limit;
      r.frame_byte    = b;
      r.byte_position = pos_next;
      r.frame_status  = STATUS_BUSY;
      r.frame_end     = 1'b0;
      if (pos_next == 0) begin
         r.byte_role    = ROLE_LENGTH;
         r.frame_length = b;
         if (b > lim) begin
            r.frame_status = STATUS_REJECT;
            r.frame_end    = 1'b1;
         end else begin
            len_held = b;
            sum_acc  = b;
            pos_next = 8'd1;
         end
      end else begin
         last           = {1'b0, len_held} + 9'd2;
         r.frame_length = len_held;
         if (pos_next == 1)
            r.byte_role = ROLE_COMMAND;
         else if ({1'b0, pos_next} < last)
            r.byte_role = ROLE_PAYLOAD;
         else
            r.byte_role = ROLE_CHECKSUM;
         sum_acc = sum_acc + b;
         if (r.byte_role == ROLE_CHECKSUM) begin
            r.frame_status = (sum_acc == 0) ? STATUS_GOOD : STATUS_BAD;
            r.frame_end    = 1'b1;
         end else begin
            pos_next = pos_next + 8'd1;
         end
      end
      if (r.frame_end)
         clear_frame();
      return 1'b1;
   endfunction

   function automatic void note_failure(string msg);
      mismatches++;
      if (mismatches <= 10)
         $display("[%0t] mismatch: %s", $realtime, msg);
   endfunction

   function automatic void check_field(string field, int want_v, int got_v);
      if (got_v != want_v)
         note_failure($sformatf("%s expected 0x%0h got 0x%0h", field, want_v, got_v));
   endfunction

   // input driver
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || req.ready) begin
         if (link_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req.valid   <= 1'b1;
            req.in_byte <= link_bytes.pop_front();
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // result receiver backpressure
   always @(posedge clock) begin
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor: predict on input transfer, check on result transfer
   always @(posedge clock) begin : monitor
      result_type want;
      result_type got;
      if (reset) begin
         clear_frame();
         sync_armed    = 1'b0;
         payload_limit = MAX_PAYLOAD_RESET;
      end else begin
         if (csr_we)
            payload_limit = csr_wdata;
         if (req.valid && req.ready) begin
            if (parse_byte(req.in_byte, want))
               results_due.push_back(want);
         end
         if (rsp.valid && rsp.ready) begin
            got.frame_byte    = rsp.frame_byte;
            got.byte_role     = role_type'(rsp.byte_role);
            got.byte_position = rsp.byte_position;
            got.frame_length  = rsp.frame_length;
            got.frame_end     = rsp.frame_end;
            got.frame_status  = status_type'(rsp.frame_status);
            if (results_due.size() == 0) begin
               note_failure($sformatf("unexpected result byte 0x%0h", got.frame_byte));
            end else begin
               want = results_due.pop_front();
               check_field("frame_byte", want.frame_byte, got.frame_byte);
               check_field("byte_role", want.byte_role, got.byte_role);
               check_field("byte_position", want.byte_position, got.byte_position);
               check_field("frame_length", want.frame_length, got.frame_length);
               check_field("frame_end", want.frame_end, got.frame_end);
               check_field("frame_status", want.frame_status, got.frame_status);
            end
         end
      end
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic push_noise();
      logic [BYTE_W-1:0] v;
      do
         v = 8'($urandom);
      while (v == SYNC_SECOND);
      link_bytes.push_back(v);
   endtask

   task automatic push_sync();
      int k;
      k = $urandom_range(99);
      if (k < 10) begin
         link_bytes.push_back(SYNC_FIRST);
         push_noise();
      end else begin
         link_bytes.push_back(SYNC_FIRST);
         if (k >= 85)
            link_bytes.push_back(SYNC_FIRST);
      end
      link_bytes.push_back(SYNC_SECOND);
   endtask

   task automatic push_frame(int len, bit good);
      logic [BYTE_W-1:0] sum;
      logic [BYTE_W-1:0] v;
      link_bytes.push_back(len[7:0]);
      frame_bytes_queued++;
      if (len > gen_limit)
         return;
      sum = len[7:0];
      for (int i = 0; i < len + 1; i++) begin
         v = 8'($urandom);
         if ($urandom_range(7) == 0)
            v = $urandom_range(1) ? SYNC_FIRST : SYNC_SECOND;
         link_bytes.push_back(v);
         sum = sum + v;
      end
      v = good ? (8'd0 - sum) : 8'($urandom);
      link_bytes.push_back(v);
      frame_bytes_queued += len + 2;
   endtask

   function automatic int pick_len();
      int p;
      p = $urandom_range(99);
      if (p < 2)
         return gen_limit;
      if (p < 12)
         return $urandom_range(255, gen_limit + 1);
      return $urandom_range((gen_limit < 12) ? gen_limit : 12, 0);
   endfunction

   task automatic random_traffic(int target);
      int start;
      int n;
      start = frame_bytes_queued;
      while (frame_bytes_queued - start < target) begin
         if ($urandom_range(99) < 15) begin
            n = $urandom_range(4, 1);
            repeat (n) push_noise();
         end else begin
            push_sync();
            push_frame(pick_len(), $urandom_range(99) < 75);
         end
      end
   endtask

   task automatic wait_idle();
      while (link_bytes.size() != 0 || req.valid || results_due.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic run_phase(int limit, int send_pct, int recv_pct, int target);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= limit[7:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
      gen_limit      = (limit > LIMIT_CAP) ? LIMIT_CAP : limit;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      push_sync();
      push_frame(gen_limit, 1'b1);
      push_sync();
      push_frame(gen_limit + 1, 1'b1);
      random_traffic(target);
   endtask

   initial begin
      reset       = 1'b1;
      csr_we      = 1'b0;
      csr_wdata   = '0;
      gen_limit   = MAX_PAYLOAD_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: lone second sync byte, first sync byte remembered across noise
      link_bytes.push_back(SYNC_SECOND);
      link_bytes.push_back(SYNC_FIRST);
      link_bytes.push_back(8'h13);
      link_bytes.push_back(SYNC_SECOND);
      push_frame(0, 1'b1);
      link_bytes.push_back(SYNC_FIRST);
      link_bytes.push_back(SYNC_SECOND);
      push_frame(1, 1'b0);
      link_bytes.push_back(SYNC_FIRST);
      link_bytes.push_back(SYNC_FIRST);
      link_bytes.push_back(SYNC_SECOND);
      push_frame(255, 1'b1);
      link_bytes.push_back(SYNC_FIRST);
      link_bytes.push_back(SYNC_SECOND);
      push_frame(MAX_PAYLOAD_RESET + 1, 1'b1);
      link_bytes.push_back(SYNC_FIRST);
      link_bytes.push_back(SYNC_SECOND);
      link_bytes.push_back(8'h00);
      link_bytes.push_back(8'hFF);
      link_bytes.push_back(8'h01);

      random_traffic(120);
      run_phase(0, 77, 0, 80);
      run_phase(255, 0, 77, 160);
      run_phase(LIMIT_CAP, 34, 34, 120);
      run_phase($urandom_range(251, 1), 0, 0, 100);
      run_phase(MAX_PAYLOAD_RESET, 34, 77, 80);
      wait_idle();
      repeat (8) @(posedge clock);

      if (mismatches == 0 && results_due.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule

[sim.f]
hw/rtl/slcfp_pkg.sv
hw/rtl/slcfp_req_if.sv
hw/rtl/slcfp_rsp_if.sv
hw/rtl/slcfp_core.sv
hw/rtl/sync_length_checksum_frame_parser.sv
dv/tb_top.sv
